// ===== rtl/barometric_sensor_compensation_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the barometric sensor compensation block
// Same-cycle and next-cycle implication checks, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants for the barometric sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEMP_CAL = 2'd0;
  localparam logic [1:0] CFG_PCAL_LO  = 2'd1;
  localparam logic [1:0] CFG_PCAL_HI  = 2'd2;
  localparam logic [1:0] CFG_P9       = 2'd3;

  // Formula constants
  localparam logic [63:0] PRESS_OFFSET = 64'd128000;
  localparam logic [63:0] ADC_FULL     = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [31:0] TEMP_ROUND   = 32'd128;
  localparam logic [63:0] VAR1_BIAS    = 64'h0000_8000_0000_0000;

  // Pipeline depths
  localparam int MUL_LAT   = 2;
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int PIPE_LAT  = 85;

endpackage

// ===== rtl/barometric_sensor_compensation.sv =====
// Throughput: one request per cycle while busy is low; busy is set in reset and clears after it.
// The pressure divider (one quotient bit per stage) sets most of the depth.
// Synchronous active-low reset clears the valid chain and calibration registers.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Fixed-point temperature and pressure compensation from raw 20-bit readings
// and factory calibration words, as a free-running pipeline.
// ----------------------------------------------------------------------------
`include "barometric_sensor_compensation_assert.svh"

module barometric_sensor_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        in_adc_temperature,
  input  logic [19:0]        in_adc_pressure,
  output logic               out_valid,
  output logic signed [31:0] out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic               out_divisor_zero,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int LAT = bsc_pkg::PIPE_LAT;

  // Control
  logic           busy_r;
  logic [LAT-2:0] vld_r;
  logic           accept;

  // Calibration
  logic [47:0] temp_cal_r;
  logic [63:0] pcal_lo_r;
  logic [63:0] pcal_hi_r;
  logic [15:0] p9_r;

  logic [31:0] t1z, t2s, t3s;
  logic [63:0] p1z, p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;

  // Temperature path
  logic [31:0] d1_r, d2_r, m1_r, m2_r, tv1_r, m3_r, fine_r, temp_r;
  logic [31:0] m1_sh, m2_sh, m3_sh, tsum, temp_nxt, fine_nxt;
  logic [19:0] adcp_r;

  // Pressure path
  logic [63:0] v1_r, v1_nxt;
  logic [63:0] aa, b5, b2, c6, c3;
  logic [63:0] b5_d [2];
  logic [63:0] b2_d [2];
  logic [63:0] c3_sh;
  logic [63:0] var2_r, s_r, x_r, x_nxt;
  logic [19:0] ad_d [9];
  logic [63:0] m6, var1_nxt, var1_r, num;
  logic [63:0] q, ps, m8, m9, m10;
  logic [63:0] pd [4];
  logic [63:0] m9_d [2];
  logic [63:0] w1_sh, w2_sh, sum_r, sum_sh, press_nxt;
  logic        fz_d [71];
  logic [31:0] td [79];

  // Output registers
  logic        out_valid_r;
  logic [31:0] out_temp_r;
  logic [31:0] out_press_r;
  logic        out_zero_r;

  assign accept = start && !busy_r;

  // Set busy in reset and clear it after reset is released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // Write calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      pcal_lo_r  <= '0;
      pcal_hi_r  <= '0;
      p9_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsc_pkg::CFG_TEMP_CAL: temp_cal_r <= cfg_data[47:0];
        bsc_pkg::CFG_PCAL_LO:  pcal_lo_r  <= cfg_data;
        bsc_pkg::CFG_PCAL_HI:  pcal_hi_r  <= cfg_data;
        bsc_pkg::CFG_P9:       p9_r       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficients
  assign t1z = {16'd0, temp_cal_r[15:0]};
  assign t2s = {{16{temp_cal_r[31]}}, temp_cal_r[31:16]};
  assign t3s = {{16{temp_cal_r[47]}}, temp_cal_r[47:32]};
  assign p1z = {48'd0, pcal_lo_r[15:0]};
  assign p2s = {{48{pcal_lo_r[31]}}, pcal_lo_r[31:16]};
  assign p3s = {{48{pcal_lo_r[47]}}, pcal_lo_r[47:32]};
  assign p4s = {{48{pcal_lo_r[63]}}, pcal_lo_r[63:48]};
  assign p5s = {{48{pcal_hi_r[15]}}, pcal_hi_r[15:0]};
  assign p6s = {{48{pcal_hi_r[31]}}, pcal_hi_r[31:16]};
  assign p7s = {{48{pcal_hi_r[47]}}, pcal_hi_r[47:32]};
  assign p8s = {{48{pcal_hi_r[63]}}, pcal_hi_r[63:48]};
  assign p9s = {{48{p9_r[15]}}, p9_r};

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-3:0], accept};
    end
  end

  // Temperature stage 1: offsets from T1
  always_ff @(posedge clk) begin
    d1_r   <= {15'd0, in_adc_temperature[19:3]} - {15'd0, temp_cal_r[15:0], 1'b0};
    d2_r   <= {16'd0, in_adc_temperature[19:4]} - t1z;
    adcp_r <= in_adc_pressure;
  end

  // Temperature stage 2: products
  always_ff @(posedge clk) begin
    m1_r <= d1_r * t2s;
    m2_r <= d2_r * d2_r;
  end

  // Temperature stage 3: scale and third product
  assign m1_sh = $signed(m1_r) >>> 11;
  assign m2_sh = $signed(m2_r) >>> 12;

  always_ff @(posedge clk) begin
    tv1_r <= m1_sh;
    m3_r  <= m2_sh * t3s;
  end

  // Temperature stage 4: fine temperature
  assign m3_sh    = $signed(m3_r) >>> 14;
  assign fine_nxt = tv1_r + m3_sh;

  always_ff @(posedge clk) begin
    fine_r <= fine_nxt;
  end

  // Temperature stage 5: centidegrees and pressure offset term
  assign tsum     = {fine_r[29:0], 2'b00} + fine_r + bsc_pkg::TEMP_ROUND;
  assign temp_nxt = $signed(tsum) >>> 8;
  assign v1_nxt   = {{32{fine_r[31]}}, fine_r} - bsc_pkg::PRESS_OFFSET;

  always_ff @(posedge clk) begin
    temp_r <= temp_nxt;
    v1_r   <= v1_nxt;
  end

  // First products of the pressure path
  bsc_mul64 u_mul_aa (.clk(clk), .a(v1_r), .b(v1_r), .prod(aa));
  bsc_mul64 u_mul_b5 (.clk(clk), .a(v1_r), .b(p5s),  .prod(b5));
  bsc_mul64 u_mul_b2 (.clk(clk), .a(v1_r), .b(p2s),  .prod(b2));

  // Second products
  bsc_mul64 u_mul_c6 (.clk(clk), .a(aa), .b(p6s), .prod(c6));
  bsc_mul64 u_mul_c3 (.clk(clk), .a(aa), .b(p3s), .prod(c3));

  // Hold linear terms and the raw pressure reading
  always_ff @(posedge clk) begin
    b5_d[0] <= b5;
    b5_d[1] <= b5_d[0];
    b2_d[0] <= b2;
    b2_d[1] <= b2_d[0];
    ad_d[0] <= adcp_r;
    for (int i = 1; i < 9; i++) begin
      ad_d[i] <= ad_d[i-1];
    end
  end

  // Sum var2 and the biased var1 term
  assign c3_sh = $signed(c3) >>> 8;

  always_ff @(posedge clk) begin
    var2_r <= c6 + {b5_d[1][46:0], 17'd0} + {p4s[28:0], 35'd0};
    s_r    <= bsc_pkg::VAR1_BIAS + c3_sh + {b2_d[1][51:0], 12'd0};
  end

  // Divisor product
  bsc_mul64 u_mul_m6 (.clk(clk), .a(s_r), .b(p1z), .prod(m6));

  // Dividend before scaling
  assign x_nxt = {bsc_pkg::ADC_FULL - {44'd0, ad_d[8]}} << 31;

  always_ff @(posedge clk) begin
    x_r <= x_nxt - var2_r;
  end

  bsc_mul64 u_mul_num (.clk(clk), .a(x_r), .b(bsc_pkg::PRESS_SCALE), .prod(num));

  // Divisor
  assign var1_nxt = $signed(m6) >>> 33;

  always_ff @(posedge clk) begin
    var1_r <= var1_nxt;
  end

  bsc_div64 u_div (.clk(clk), .num(num), .den(var1_r), .quot(q));

  // Correction products
  assign ps = $signed(q) >>> 13;

  bsc_mul64 u_mul_m8  (.clk(clk), .a(ps),  .b(ps), .prod(m8));
  bsc_mul64 u_mul_m9  (.clk(clk), .a(p8s), .b(q),  .prod(m9));
  bsc_mul64 u_mul_m10 (.clk(clk), .a(p9s), .b(m8), .prod(m10));

  // Hold quotient, flag and temperature alongside
  always_ff @(posedge clk) begin
    pd[0]   <= q;
    for (int i = 1; i < 4; i++) begin
      pd[i] <= pd[i-1];
    end
    m9_d[0] <= m9;
    m9_d[1] <= m9_d[0];
    fz_d[0] <= (var1_r == 64'd0);
    for (int i = 1; i < 71; i++) begin
      fz_d[i] <= fz_d[i-1];
    end
    td[0]   <= temp_r;
    for (int i = 1; i < 79; i++) begin
      td[i] <= td[i-1];
    end
  end

  // Sum corrections
  assign w1_sh = $signed(m10) >>> 25;
  assign w2_sh = $signed(m9_d[1]) >>> 19;

  always_ff @(posedge clk) begin
    sum_r <= pd[3] + w1_sh + w2_sh;
  end

  // Final pressure
  assign sum_sh    = $signed(sum_r) >>> 8;
  assign press_nxt = sum_sh + {p7s[59:0], 4'd0};

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    out_temp_r  <= td[78];
    out_zero_r  <= fz_d[70];
    out_press_r <= fz_d[70] ? 32'd0 : press_nxt[31:0];
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_temp_r;
  assign out_pressure_q24_8    = out_press_r;
  assign out_divisor_zero      = out_zero_r;

  // Checks
  `BSC_ASSERT_IMP(a_zero_press, clk, rst_n, out_valid && out_divisor_zero, out_pressure_q24_8 == 32'd0, "pressure not forced to zero on zero divisor")
  `BSC_ASSERT_IMP(a_out_origin, clk, rst_n, out_valid, $past(start && !busy, LAT), "result strobe without a matching request")
  `BSC_ASSERT_NXT(a_cfg_p9, clk, rst_n, cfg_valid && cfg_ready && cfg_index == bsc_pkg::CFG_P9, p9_r == $past(cfg_data[15:0]), "P9 write lost")

endmodule

// ===== rtl/bsc_mul64.sv =====
// ----------------------------------------------------------------------------
// bsc_mul64
// Two-stage 64 x 64 multiplier that keeps the low 64 bits of the product,
// built from three 32 x 32 partial products.
// ----------------------------------------------------------------------------
module bsc_mul64 (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] prod
);

  logic [63:0] ll_r;
  logic [31:0] hl_r;
  logic [31:0] lh_r;
  logic [63:0] ll_nxt;
  logic [31:0] hl_nxt;
  logic [31:0] lh_nxt;
  logic [63:0] prod_r;
  logic [63:0] prod_nxt;

  // Form partial products; cross terms only feed the upper word
  assign ll_nxt = {32'd0, a[31:0]} * {32'd0, b[31:0]};
  assign hl_nxt = a[63:32] * b[31:0];
  assign lh_nxt = a[31:0] * b[63:32];

  always_ff @(posedge clk) begin
    ll_r <= ll_nxt;
    hl_r <= hl_nxt;
    lh_r <= lh_nxt;
  end

  // Combine cross terms into the upper word
  assign prod_nxt = ll_r + {hl_r + lh_r, 32'd0};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// ===== rtl/bsc_div64.sv =====
// ----------------------------------------------------------------------------
// bsc_div64
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit
// per stage. It has one sign stage, one stage per bit and one fixup stage.
// ----------------------------------------------------------------------------
module bsc_div64 (
  input  logic        clk,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quot
);

  localparam int STEPS = bsc_pkg::DIV_STEPS;

  logic [63:0] rem_r [STEPS+1];
  logic [63:0] nq_r  [STEPS+1];
  logic [63:0] den_r [STEPS+1];
  logic        neg_r [STEPS+1];
  logic [63:0] quot_r;
  logic [63:0] num_abs;
  logic [63:0] den_abs;

  // Take magnitudes and the result sign
  assign num_abs = num[63] ? (64'd0 - num) : num;
  assign den_abs = den[63] ? (64'd0 - den) : den;

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    nq_r[0]  <= num_abs;
    den_r[0] <= den_abs;
    neg_r[0] <= num[63] ^ den[63];
  end

  // One restoring step per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [64:0] trial;
    logic [64:0] diff;
    logic        take;

    assign trial = {rem_r[i], nq_r[i][63]};
    assign diff  = trial - {1'b0, den_r[i]};
    assign take  = (trial >= {1'b0, den_r[i]});

    always_ff @(posedge clk) begin
      rem_r[i+1] <= take ? diff[63:0] : trial[63:0];
      nq_r[i+1]  <= {nq_r[i][62:0], take};
      den_r[i+1] <= den_r[i];
      neg_r[i+1] <= neg_r[i];
    end
  end

  // Apply the sign
  always_ff @(posedge clk) begin
    quot_r <= neg_r[STEPS] ? (64'd0 - nq_r[STEPS]) : nq_r[STEPS];
  end

  assign quot = quot_r;

endmodule
